[hdl/weighted_node_set_picker_assert.svh]
// Assertion helpers; expect clk and rst in scope.
`ifndef WEIGHTED_NODE_SET_PICKER_ASSERT_SVH
`define WEIGHTED_NODE_SET_PICKER_ASSERT_SVH

// condition holds at every edge outside reset
`define WNSP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// pre at one edge implies post at the next
`define WNSP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/wnsp_pkg.sv]
`default_nettype none
package wnsp_pkg;

  localparam int MaxEntries = 64;
  localparam int IdBits     = 16;

  localparam int IdMaxW  = 16;
  localparam int WgtW    = 15;
  localparam int SumW    = 22;
  localparam int CntMaxW = 11;
  localparam int IxW     = 31;

  localparam logic [SumW-1:0] SumMax    = 22'h3FFFFF;
  localparam logic [20:0]     OutSumMax = 21'h1FFFFF;

  localparam logic [1:0] OpAdd   = 2'd0;
  localparam logic [1:0] OpPick  = 2'd1;
  localparam logic [1:0] OpQuery = 2'd2;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StOrder    = 3'd1;
  localparam logic [2:0] StWeight   = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StNoPick   = 3'd4;

  typedef struct packed {
    logic [1:0]        operation;
    logic [15:0]       node_id;
    logic signed [15:0] node_weight;
    logic [30:0]       unit_index;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        picked_node;
    logic signed [15:0] found_weight;
    logic [2:0]         status;
    logic [6:0]         entry_total;
    logic [20:0]        weight_total;
  } rsp_t;

  // search word passed cell to cell
  typedef struct packed {
    logic               valid;
    logic               is_query;
    logic               rr;
    logic               done;
    logic [CntMaxW-1:0] left;
    logic [SumW-1:0]    rem;
    logic [IdMaxW-1:0]  key;
    logic [IdMaxW-1:0]  res_id;
    logic [WgtW-1:0]    res_w;
  } probe_t;

endpackage
`default_nettype wire

[hdl/wnsp_cell.sv]
`default_nettype none
module wnsp_cell (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               wr_en,
  input  wire logic [wnsp_pkg::IdMaxW-1:0]        wr_id,
  input  wire logic [wnsp_pkg::WgtW-1:0]          wr_w,
  input  wire wnsp_pkg::probe_t                   probe_in,
  output wnsp_pkg::probe_t                        probe_out
);

  logic [wnsp_pkg::IdMaxW-1:0] id;
  logic [wnsp_pkg::WgtW-1:0]   w;
  logic [wnsp_pkg::SumW-1:0]   w_eff;
  logic                        active;
  wnsp_pkg::probe_t            nxt;

  assign active = probe_in.valid && !probe_in.done && (probe_in.left != '0);
  assign w_eff  = probe_in.rr ? wnsp_pkg::SumW'(1) : wnsp_pkg::SumW'(w);

  always_comb begin
    nxt = probe_in;
    if (active) begin
      nxt.left = probe_in.left - 1'b1;
      if (probe_in.is_query) begin
        if (probe_in.key == id) begin
          nxt.done  = 1'b1;
          nxt.res_w = w;
        end
      end else if (probe_in.rem < w_eff) begin
        nxt.done   = 1'b1;
        nxt.res_id = id;
      end else begin
        nxt.rem = probe_in.rem - w_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id <= wr_id;
      w  <= wr_w;
    end
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/wnsp_div.sv]
`default_nettype none
// restoring remainder, one dividend bit per cycle
module wnsp_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [wnsp_pkg::IxW-1:0]       dividend,
  input  wire logic [wnsp_pkg::SumW-1:0]      divisor,
  output logic                                done,
  output logic [wnsp_pkg::SumW-1:0]           rem
);

  localparam int StepW = $clog2(wnsp_pkg::IxW + 1);

  logic [wnsp_pkg::IxW-1:0]  q;
  logic [wnsp_pkg::SumW-1:0] d;
  logic [StepW-1:0]          steps;
  logic [wnsp_pkg::SumW:0]   t;

  assign t = {rem, q[wnsp_pkg::IxW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q     <= dividend;
        d     <= divisor;
        rem   <= '0;
        steps <= StepW'(wnsp_pkg::IxW);
      end else if (steps != '0) begin
        q     <= q << 1;
        rem   <= (t >= {1'b0, d}) ? wnsp_pkg::SumW'(t - {1'b0, d})
                                  : wnsp_pkg::SumW'(t);
        steps <= steps - 1'b1;
        done  <= (steps == StepW'(1));
      end
    end
  end

endmodule
`default_nettype wire

[hdl/weighted_node_set_picker.sv]
`default_nettype none
// Weighted node set picker.
// cmd channel (cmd_valid/cmd_stall/cmd) takes one word: add an entry, pick a
// node for a unit index, or query a node's weight. rsp channel returns exactly
// one word per command, in order.
// Entries live in a chain of MAX_ENTRIES cells; pick and query send a probe
// word down the chain, one cell per cycle.
// Add and unused codes go straight to the output state; query walks the chain
// first; pick runs the remainder unit (one bit a cycle) and then walks the
// chain; an impossible pick goes straight to output. One command is in
// flight at a time: a new one is taken only once the last word is on rsp.
// cmd_stall is high while a command is being worked; a finished word waits
// in a holding register while rsp is stalled, and rsp holds steady.
// Reset (rst, synchronous) empties the table and clears both channels.
module weighted_node_set_picker #(
  parameter int MAX_ENTRIES = wnsp_pkg::MaxEntries,
  parameter int ID_BITS     = wnsp_pkg::IdBits
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_stall,
  input  wire wnsp_pkg::cmd_t   cmd,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output wnsp_pkg::rsp_t        rsp
);

`include "weighted_node_set_picker_assert.svh"

  localparam int CntW = $clog2(MAX_ENTRIES + 1);
  localparam int IdW  = (ID_BITS < wnsp_pkg::IdMaxW) ? ID_BITS : wnsp_pkg::IdMaxW;
  localparam logic [15:0] IdMask = 16'((32'h1 << IdW) - 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_WALK, S_OUT} state_t;

  state_t                      st;
  logic [CntW-1:0]             cnt;
  logic [wnsp_pkg::SumW-1:0]   sum;
  logic [wnsp_pkg::WgtW-1:0]   shared_w;
  logic                        differ;
  logic                        unspec;
  logic [15:0]                 last_id;
  wnsp_pkg::rsp_t              res;
  wnsp_pkg::probe_t            probe_head;
  wnsp_pkg::probe_t            chain [MAX_ENTRIES+1];

  logic                        accept;
  logic [15:0]                 id_in;
  logic                        w_unspec;
  logic                        w_pos;
  logic [wnsp_pkg::WgtW-1:0]   uw;
  logic [2:0]                  add_status;
  logic                        add_ok;
  logic [wnsp_pkg::SumW:0]     sum_add;
  logic [wnsp_pkg::SumW-1:0]   sum_next;
  logic [CntW-1:0]             cnt_next;
  logic                        pick_ok;
  logic                        div_start;
  logic                        div_done;
  logic [wnsp_pkg::SumW-1:0]   div_rem;
  logic                        rsp_free;
  wnsp_pkg::probe_t            tail;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (st != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign id_in     = cmd.node_id & IdMask;
  assign w_unspec  = (cmd.node_weight == -16'sd1);
  assign w_pos     = !cmd.node_weight[15] && (cmd.node_weight != 16'sd0);
  assign uw        = w_unspec ? '0 : cmd.node_weight[14:0];
  assign pick_ok   = (cnt != '0) && !unspec && (sum != '0);
  assign div_start = accept && (cmd.operation == wnsp_pkg::OpPick) && pick_ok;
  assign sum_add   = {1'b0, sum} + (wnsp_pkg::SumW + 1)'(uw);
  assign sum_next  = (sum_add > {1'b0, wnsp_pkg::SumMax}) ? wnsp_pkg::SumMax
                                                          : sum_add[wnsp_pkg::SumW-1:0];
  assign cnt_next  = cnt + 1'b1;
  assign tail      = chain[MAX_ENTRIES];

  always_comb begin
    priority if (32'(cnt) >= MAX_ENTRIES) begin
      add_status = wnsp_pkg::StFull;
    end else if (cnt != '0 && last_id >= id_in) begin
      add_status = wnsp_pkg::StOrder;
    end else if (!(w_pos || w_unspec)) begin
      add_status = wnsp_pkg::StWeight;
    end else if (cnt != '0 && w_unspec != unspec) begin
      add_status = wnsp_pkg::StWeight;
    end else begin
      add_status = wnsp_pkg::StOk;
    end
  end
  assign add_ok = accept && (cmd.operation == wnsp_pkg::OpAdd)
                  && (add_status == wnsp_pkg::StOk);

  assign chain[0] = probe_head;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    wnsp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (add_ok && (cnt == CntW'(i))),
      .wr_id     (id_in),
      .wr_w      (uw),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1])
    );
  end

  wnsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cmd.unit_index),
    .divisor  (differ ? sum : wnsp_pkg::SumW'(cnt)),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      cnt        <= '0;
      sum        <= '0;
      shared_w   <= '0;
      differ     <= 1'b0;
      unspec     <= 1'b0;
      rsp_valid  <= 1'b0;
      probe_head <= '0;
    end else begin
      probe_head.valid <= 1'b0;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (accept) begin
            res                <= '0;
            res.entry_total    <= (32'(cnt) > 127) ? 7'd127 : 7'(cnt);
            res.weight_total   <= (sum > 22'(wnsp_pkg::OutSumMax)) ? wnsp_pkg::OutSumMax
                                                                  : sum[20:0];
            st                 <= S_OUT;
            unique case (cmd.operation)
              wnsp_pkg::OpAdd: begin
                res.status <= add_status;
                if (add_ok) begin
                  cnt     <= cnt_next;
                  sum     <= sum_next;
                  last_id <= id_in;
                  res.entry_total  <= (32'(cnt_next) > 127) ? 7'd127 : 7'(cnt_next);
                  res.weight_total <= (sum_next > 22'(wnsp_pkg::OutSumMax))
                                      ? wnsp_pkg::OutSumMax : sum_next[20:0];
                  if (cnt == '0) begin
                    shared_w <= uw;
                    unspec   <= w_unspec;
                    differ   <= 1'b0;
                  end else if (uw != shared_w) begin
                    differ <= 1'b1;
                  end
                end
              end
              wnsp_pkg::OpPick: begin
                if (pick_ok) begin
                  st <= S_DIV;
                end else begin
                  res.status <= wnsp_pkg::StNoPick;
                end
              end
              wnsp_pkg::OpQuery: begin
                probe_head          <= '0;
                probe_head.valid    <= 1'b1;
                probe_head.is_query <= 1'b1;
                probe_head.left     <= wnsp_pkg::CntMaxW'(cnt);
                probe_head.key      <= id_in;
                st                  <= S_WALK;
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            probe_head       <= '0;
            probe_head.valid <= 1'b1;
            probe_head.rr    <= !differ;
            probe_head.left  <= wnsp_pkg::CntMaxW'(cnt);
            probe_head.rem   <= div_rem;
            st               <= S_WALK;
          end
        end
        S_WALK: begin
          if (tail.valid) begin
            if (tail.is_query) begin
              res.found_weight <= !tail.done ? 16'sd0
                                  : (unspec ? -16'sd1 : $signed({1'b0, tail.res_w}));
            end else begin
              res.picked_node <= tail.done ? tail.res_id : last_id;
            end
            st <= S_OUT;
          end
        end
        S_OUT: begin
          if (rsp_free) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            st        <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `WNSP_ASSERT_ALWAYS(a_cnt_bound, (32'(cnt) <= MAX_ENTRIES), "entry count beyond table")
  `WNSP_ASSERT_ALWAYS(a_differ_needs_two, (!differ || (32'(cnt) >= 2)), "weights differ with under two entries")
  `WNSP_ASSERT_ALWAYS(a_div_done_state, (!div_done || st == S_DIV), "remainder done outside divide state")
  `WNSP_ASSERT_NEXT(a_accept_busy, accept, cmd_stall, "command taken but block not busy")

endmodule
`default_nettype wire

[bench/tb_weighted_node_set_picker.sv]
`default_nettype none
module tb_weighted_node_set_picker;

  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles = 400;
  localparam logic [1:0] OpUnused = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  wnsp_pkg::cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  wnsp_pkg::rsp_t rsp;

  weighted_node_set_picker i_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // table mirror
  logic [15:0] tbl_id [wnsp_pkg::MaxEntries];
  logic [14:0] tbl_wgt [wnsp_pkg::MaxEntries];
  int unsigned tbl_count = 0;
  int unsigned tbl_sum = 0;
  int unsigned tbl_shared = 0;
  bit tbl_differ = 0;
  bit tbl_unspec = 0;

  wnsp_pkg::rsp_t pending_rsp [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int words_in = 0;
  int words_out = 0;
  int status_seen [8];
  int op_seen [4];

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("mismatch on word %0d: %s got %0d expected %0d", words_out, what, got, exp);
    errors++;
  endtask

  function automatic logic [2:0] table_add(input logic [15:0] id,
                                           input logic signed [15:0] w);
    int unsigned uw;
    bit unspec;
    unspec = (w == -16'sd1);
    if (tbl_count >= wnsp_pkg::MaxEntries) return wnsp_pkg::StFull;
    if (tbl_count > 0 && tbl_id[tbl_count-1] >= id) return wnsp_pkg::StOrder;
    if (!(w > 0 || unspec)) return wnsp_pkg::StWeight;
    if (tbl_count > 0 && unspec != tbl_unspec) return wnsp_pkg::StWeight;
    uw = unspec ? 0 : int'(w);
    tbl_id[tbl_count] = id;
    tbl_wgt[tbl_count] = uw[14:0];
    if (tbl_count == 0) begin
      tbl_shared = uw;
      tbl_unspec = unspec;
      tbl_differ = 0;
    end else if (uw != tbl_shared) begin
      tbl_differ = 1;
    end
    tbl_sum = tbl_sum + uw;
    if (tbl_sum > wnsp_pkg::SumMax) tbl_sum = wnsp_pkg::SumMax;
    tbl_count++;
    return wnsp_pkg::StOk;
  endfunction

  function automatic wnsp_pkg::rsp_t predict_answer(input wnsp_pkg::cmd_t c);
    wnsp_pkg::rsp_t r;
    int unsigned u;
    bit hit;
    r = '0;
    hit = 0;
    case (c.operation)
      wnsp_pkg::OpAdd: r.status = table_add(c.node_id, c.node_weight);
      wnsp_pkg::OpPick: begin
        if (tbl_count == 0 || tbl_unspec || tbl_sum == 0) begin
          r.status = wnsp_pkg::StNoPick;
        end else if (!tbl_differ) begin
          r.picked_node = tbl_id[c.unit_index % tbl_count];
        end else begin
          u = c.unit_index % tbl_sum;
          r.picked_node = tbl_id[tbl_count-1];
          for (int i = 0; i < tbl_count; i++) begin
            if (!hit) begin
              if (u < tbl_wgt[i]) begin
                r.picked_node = tbl_id[i];
                hit = 1;
              end else begin
                u = u - tbl_wgt[i];
              end
            end
          end
        end
      end
      wnsp_pkg::OpQuery: begin
        for (int i = 0; i < tbl_count; i++)
          if (!hit && tbl_id[i] == c.node_id) begin
            r.found_weight = tbl_unspec ? -16'sd1 : {1'b0, tbl_wgt[i]};
            hit = 1;
          end
      end
      default: ;
    endcase
    r.entry_total = (tbl_count > 127) ? 7'd127 : tbl_count[6:0];
    r.weight_total = (tbl_sum > wnsp_pkg::OutSumMax) ? wnsp_pkg::OutSumMax : tbl_sum[20:0];
    return r;
  endfunction

  // one word on cmd; valid stays high afterwards unless the next call idles or wait_drain runs
  task automatic send_word(input wnsp_pkg::cmd_t c);
    if ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    pending_rsp.push_back(predict_answer(c));
    op_seen[c.operation]++;
    words_in++;
  endtask

  task automatic send_op(input logic [1:0] op, input logic [15:0] id,
                         input logic signed [15:0] w, input logic [30:0] ix);
    wnsp_pkg::cmd_t c;
    c.operation = op;
    c.node_id = id;
    c.node_weight = w;
    c.unit_index = ix;
    send_word(c);
  endtask

  task automatic wait_drain();
    cmd_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic wnsp_pkg::cmd_t random_word();
    wnsp_pkg::cmd_t c;
    int sel;
    int unsigned last;
    c.operation = wnsp_pkg::OpPick;
    c.node_id = 16'($urandom);
    c.unit_index = 31'($urandom);
    c.node_weight = 16'($urandom_range(1, 8));
    sel = $urandom_range(99);
    last = (tbl_count > 0) ? 32'(tbl_id[tbl_count-1]) : 0;
    if (sel < 35) begin
      c.operation = wnsp_pkg::OpAdd;
      if ($urandom_range(9) < 7 && last < 65535) begin
        c.node_id = (tbl_count == wnsp_pkg::MaxEntries - 1 || last > 64000) ? 16'hFFFF :
                    16'(last + $urandom_range(1, 900));
        case ($urandom_range(3))
          0: c.node_weight = 16'(tbl_shared);
          1: c.node_weight = 16'($urandom_range(1, 32767));
          default: ;
        endcase
      end else begin
        case ($urandom_range(3))
          0: c.node_id = 16'(last - $urandom_range(0, 3));
          1: c.node_weight = 16'sd0;
          2: c.node_weight = 16'sd1 - 16'($urandom_range(1, 32768));
          default: c.node_weight = -16'sd1;
        endcase
      end
    end else if (sel < 65) begin
      c.operation = wnsp_pkg::OpQuery;
      if (tbl_count > 0 && $urandom_range(2) != 0)
        c.node_id = tbl_id[$urandom_range(tbl_count - 1)] + 16'($urandom_range(1) == 0);
    end else if (sel < 68) begin
      c.operation = OpUnused;
    end
    return c;
  endfunction

  task automatic run_random(input int n, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_word(random_word());
    wait_drain();
  endtask

  task automatic test_empty_table();
    send_op(wnsp_pkg::OpPick, 16'd0, 16'sd0, 31'h7FFFFFFF);
    send_op(wnsp_pkg::OpQuery, 16'hFFFF, 16'sd0, 31'd0);
    send_op(OpUnused, 16'h1234, 16'sd7, 31'd9);
    send_op(wnsp_pkg::OpAdd, 16'd3, 16'sd0, 31'd0);
    send_op(wnsp_pkg::OpAdd, 16'd3, -16'sd2, 31'd0);
    send_op(wnsp_pkg::OpAdd, 16'd3, -16'sd32768, 31'd0);
  endtask

  task automatic test_round_robin();
    send_op(wnsp_pkg::OpAdd, 16'd0, 16'sd5, 31'd0);
    send_op(wnsp_pkg::OpAdd, 16'd0, 16'sd5, 31'd0);
    send_op(wnsp_pkg::OpAdd, 16'd2, 16'sd5, 31'd0);
    send_op(wnsp_pkg::OpAdd, 16'd1, 16'sd5, 31'd0);
    send_op(wnsp_pkg::OpAdd, 16'd7, -16'sd1, 31'd0);
    send_op(wnsp_pkg::OpAdd, 16'd9, 16'sd5, 31'd0);
    for (int i = 0; i < 4; i++) send_op(wnsp_pkg::OpPick, 16'd0, 16'sd0, 31'(i));
    send_op(wnsp_pkg::OpPick, 16'd0, 16'sd0, 31'h7FFFFFFF);
    send_op(wnsp_pkg::OpQuery, 16'd2, 16'sd0, 31'd0);
    send_op(wnsp_pkg::OpQuery, 16'd3, 16'sd0, 31'd0);
  endtask

  task automatic test_weighted();
    send_op(wnsp_pkg::OpAdd, 16'd40, 16'sd32767, 31'd0);
    send_op(wnsp_pkg::OpPick, 16'd0, 16'sd0, 31'd14);
    send_op(wnsp_pkg::OpPick, 16'd0, 16'sd0, 31'd15);
    send_op(wnsp_pkg::OpPick, 16'd0, 16'sd0, 31'h7FFFFFFF);
    send_op(wnsp_pkg::OpQuery, 16'd40, 16'sd0, 31'd0);
    wait_drain();
  endtask

  task automatic test_hold_off();
    idle_pct = 0;
    stall_pct = 0;
    hold_reqs++;
    for (int i = 0; i < 60; i++) send_word(random_word());
    wait_drain();
  endtask

  // receiver: long hold on request, else random stalls
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldCycles - 1;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    wnsp_pkg::rsp_t exp;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected rsp word", 1, 0);
      end else begin
        exp = pending_rsp.pop_front();
        if (rsp.picked_node !== exp.picked_node)
          report_mismatch("picked_node", rsp.picked_node, exp.picked_node);
        if (rsp.found_weight !== exp.found_weight)
          report_mismatch("found_weight", rsp.found_weight, exp.found_weight);
        if (rsp.status !== exp.status)
          report_mismatch("status", rsp.status, exp.status);
        if (rsp.entry_total !== exp.entry_total)
          report_mismatch("entry_total", rsp.entry_total, exp.entry_total);
        if (rsp.weight_total !== exp.weight_total)
          report_mismatch("weight_total", rsp.weight_total, exp.weight_total);
        status_seen[exp.status]++;
      end
      words_out++;
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d words outstanding", pending_rsp.size());
      $display("tb_weighted_node_set_picker: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_round_robin();
    test_weighted();
    run_random(400, 0, 0);
    run_random(400, 70, 0);
    test_hold_off();
    run_random(400, 0, 70);
    run_random(450, 33, 33);
    wait_drain();
    repeat (200) @(posedge clk);
    $display("%0d cmd words, %0d rsp words; adds %0d picks %0d queries %0d unused %0d",
             words_in, words_out, op_seen[wnsp_pkg::OpAdd], op_seen[wnsp_pkg::OpPick],
             op_seen[wnsp_pkg::OpQuery], op_seen[OpUnused]);
    $display("status ok %0d order %0d weight %0d full %0d nopick %0d; table %0d entries",
             status_seen[wnsp_pkg::StOk], status_seen[wnsp_pkg::StOrder],
             status_seen[wnsp_pkg::StWeight], status_seen[wnsp_pkg::StFull],
             status_seen[wnsp_pkg::StNoPick], tbl_count);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("tb_weighted_node_set_picker: PASS");
    end else begin
      $display("tb_weighted_node_set_picker: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
